// ===== rtl/retransmit_confirm_table_defines.svh =====
// Assertion macros for the file that checks its own logic.
`ifndef RETRANSMIT_CONFIRM_TABLE_DEFINES_SVH
`define RETRANSMIT_CONFIRM_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rct_pkg.sv =====
package rct_pkg;

	localparam int SLOT_COUNT  = 16;
	localparam int SLOT_IW     = $clog2(SLOT_COUNT);
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd1;

	localparam logic [15:0] TIMEOUT_RESET     = 16'd250;
	localparam logic [2:0]  RETRY_LIMIT_RESET = 3'd3;

	typedef enum logic [1:0] {
		KIND_SEND    = 2'd0,
		KIND_CONFIRM = 2'd1,
		KIND_TICK    = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		STAT_SENT       = 3'd0,
		STAT_FULL       = 3'd1,
		STAT_CONFIRMED  = 3'd2,
		STAT_UNMATCHED  = 3'd3,
		STAT_RETRANSMIT = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEND,
		ST_READ,
		ST_EVAL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] now_ms;
		logic [15:0] confirm_seq;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  slot_index;
		logic [15:0] seq_out;
		logic [2:0]  retry_count;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [15:0] seq;
		logic [31:0] sent_time;
		logic [2:0]  retries;
	} slot_entry_t;

	typedef struct packed {
		logic load;
		logic step;
		logic send_wr;
		logic confirm_hit;
		logic confirm_miss;
		logic tick_hit;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic [1:0] in_kind;
		logic [1:0] kind;
		logic       hit;
		logic       idx_last;
		logic       pend_valid;
		logic       out_free;
	} sts_t;

endpackage

// ===== rtl/rct_ram.sv =====
module rct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rct_ctrl.sv =====
module rct_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rct_pkg::sts_t sts,
	output rct_pkg::cmd_t cmd
);

	rct_pkg::state_t state_q, state_d;
	logic            blocked;

	// A due slot cannot be taken while an earlier result has nowhere to go.
	assign blocked = sts.pend_valid && !sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rct_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rct_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (sts.in_kind)
						rct_pkg::KIND_SEND: state_d = rct_pkg::ST_SEND;
						rct_pkg::KIND_CONFIRM,
						rct_pkg::KIND_TICK: state_d = rct_pkg::ST_READ;
						default: state_d = rct_pkg::ST_IDLE;
					endcase
				end
			end
			rct_pkg::ST_SEND: state_d = rct_pkg::ST_FINISH;
			rct_pkg::ST_READ: state_d = rct_pkg::ST_EVAL;
			rct_pkg::ST_EVAL: begin
				if (sts.hit && sts.kind == rct_pkg::KIND_CONFIRM) begin
					state_d = rct_pkg::ST_FINISH;
				end else if (sts.hit && blocked) begin
					state_d = rct_pkg::ST_EVAL;
				end else if (sts.idx_last) begin
					state_d = rct_pkg::ST_FINISH;
				end else begin
					state_d = rct_pkg::ST_READ;
				end
			end
			rct_pkg::ST_FINISH: begin
				if (!sts.pend_valid || sts.out_free) begin
					state_d = rct_pkg::ST_IDLE;
				end
			end
			default: state_d = rct_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			rct_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			rct_pkg::ST_SEND: cmd.send_wr = 1'b1;
			rct_pkg::ST_READ: cmd = '0;
			rct_pkg::ST_EVAL: begin
				if (sts.hit) begin
					if (sts.kind == rct_pkg::KIND_CONFIRM) begin
						cmd.confirm_hit = 1'b1;
					end else if (!blocked) begin
						cmd.tick_hit = 1'b1;
						cmd.step     = !sts.idx_last;
					end
				end else begin
					cmd.step         = !sts.idx_last;
					cmd.confirm_miss = sts.idx_last && sts.kind == rct_pkg::KIND_CONFIRM;
				end
			end
			rct_pkg::ST_FINISH: cmd.flush = sts.pend_valid && sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/rct_datapath.sv =====
module rct_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rct_pkg::cmd_t                   cmd,
	output rct_pkg::sts_t                   sts,
	input  rct_pkg::in_item_t               in_data,
	input  logic                            out_ready,
	output logic                            out_valid,
	output rct_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	input  logic [rct_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rct_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int EW = $bits(rct_pkg::slot_entry_t);

	logic [1:0]                  kind_q;
	logic [31:0]                 now_q;
	logic [15:0]                 cseq_q;
	logic [rct_pkg::SLOT_IW-1:0] idx_q;
	logic [rct_pkg::CNT_W-1:0]   cnt_q;
	logic [rct_pkg::SLOT_COUNT-1:0] valid_q;
	logic [15:0]                 next_seq_q;
	logic [15:0]                 timeout_q;
	logic [2:0]                  limit_q;
	logic                        pend_valid_q;
	rct_pkg::out_item_t          pend_q;
	logic                        out_valid_q;
	rct_pkg::out_item_t          out_q;

	rct_pkg::slot_entry_t        rd_entry;
	rct_pkg::slot_entry_t        wr_entry;
	logic [EW-1:0]               rd_bits;
	logic                        ram_we;
	logic [rct_pkg::SLOT_IW-1:0] ram_waddr;
	logic [rct_pkg::SLOT_IW-1:0] free_idx;
	logic                        free_found;
	logic [31:0]                 elapsed;
	logic [2:0]                  retries_inc;
	logic                        due;
	logic                        match;
	logic                        out_free;
	logic                        push;

	// Lowest free slot.
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = rct_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx   = rct_pkg::SLOT_IW'(i);
				free_found = 1'b1;
			end
		end
	end

	assign rd_entry    = rct_pkg::slot_entry_t'(rd_bits);
	assign elapsed     = now_q - rd_entry.sent_time;
	assign retries_inc = rd_entry.retries + 3'd1;
	assign match       = valid_q[idx_q] && rd_entry.seq == cseq_q;
	assign due         = valid_q[idx_q] && elapsed >= {16'd0, timeout_q}
	                     && rd_entry.retries < limit_q
	                     && cnt_q < rct_pkg::CNT_W'(rct_pkg::MAX_RESULTS);

	assign ram_we    = (cmd.send_wr && free_found) || cmd.tick_hit;
	assign ram_waddr = cmd.send_wr ? free_idx : idx_q;

	always_comb begin
		if (cmd.send_wr) begin
			wr_entry.seq       = next_seq_q;
			wr_entry.sent_time = now_q;
			wr_entry.retries   = 3'd0;
		end else begin
			wr_entry.seq       = rd_entry.seq;
			wr_entry.sent_time = now_q;
			wr_entry.retries   = retries_inc;
		end
	end

	rct_ram #(
		.WIDTH(EW),
		.DEPTH(rct_pkg::SLOT_COUNT)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_entry),
		.raddr(idx_q),
		.rdata(rd_bits)
	);

	assign out_free = !out_valid_q || out_ready;
	assign push     = cmd.flush || (cmd.tick_hit && pend_valid_q);

	always_comb begin
		sts.in_kind    = in_data.kind;
		sts.kind       = kind_q;
		sts.idx_last   = idx_q == rct_pkg::SLOT_IW'(rct_pkg::SLOT_COUNT - 1);
		sts.pend_valid = pend_valid_q;
		sts.out_free   = out_free;
		case (kind_q)
			rct_pkg::KIND_CONFIRM: sts.hit = match;
			rct_pkg::KIND_TICK:    sts.hit = due;
			default:               sts.hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_data.kind;
			now_q  <= in_data.now_ms;
			cseq_q <= in_data.confirm_seq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			cnt_q      <= '0;
			valid_q    <= '0;
			next_seq_q <= '0;
			timeout_q  <= rct_pkg::TIMEOUT_RESET;
			limit_q    <= rct_pkg::RETRY_LIMIT_RESET;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				cnt_q <= '0;
			end else begin
				if (cmd.step) begin
					idx_q <= idx_q + 1'b1;
				end
				if (cmd.tick_hit) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.send_wr && free_found) begin
				valid_q[free_idx] <= 1'b1;
				next_seq_q        <= next_seq_q + 16'd1;
			end
			if (cmd.confirm_hit) begin
				valid_q[idx_q] <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					rct_pkg::CFG_TIMEOUT:     timeout_q <= cfg_data;
					rct_pkg::CFG_RETRY_LIMIT: limit_q   <= cfg_data[2:0];
					default: ;
				endcase
			end
		end
	end

	// One result waits in the pending register until the next one, or the end of
	// the scan, tells whether it is the last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.send_wr || cmd.confirm_hit || cmd.confirm_miss || cmd.tick_hit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q.status      <= pend_q.status;
			out_q.slot_index  <= pend_q.slot_index;
			out_q.seq_out     <= pend_q.seq_out;
			out_q.retry_count <= pend_q.retry_count;
			out_q.last        <= cmd.flush;
		end
		if (cmd.send_wr) begin
			pend_q.status      <= free_found ? rct_pkg::STAT_SENT : rct_pkg::STAT_FULL;
			pend_q.slot_index  <= free_found ? 4'(free_idx) : 4'd0;
			pend_q.seq_out     <= next_seq_q;
			pend_q.retry_count <= 3'd0;
			pend_q.last        <= 1'b0;
		end else if (cmd.confirm_hit) begin
			pend_q.status      <= rct_pkg::STAT_CONFIRMED;
			pend_q.slot_index  <= 4'(idx_q);
			pend_q.seq_out     <= rd_entry.seq;
			pend_q.retry_count <= rd_entry.retries;
			pend_q.last        <= 1'b0;
		end else if (cmd.confirm_miss) begin
			pend_q.status      <= rct_pkg::STAT_UNMATCHED;
			pend_q.slot_index  <= 4'd0;
			pend_q.seq_out     <= cseq_q;
			pend_q.retry_count <= 3'd0;
			pend_q.last        <= 1'b0;
		end else if (cmd.tick_hit) begin
			pend_q.status      <= rct_pkg::STAT_RETRANSMIT;
			pend_q.slot_index  <= 4'(idx_q);
			pend_q.seq_out     <= rd_entry.seq;
			pend_q.retry_count <= retries_inc;
			pend_q.last        <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/retransmit_confirm_table.sv =====
// Retransmission table for datagrams that wait for confirmation.
// The input channel (in_valid, in_ready, in_data) takes one event per transaction:
// send, confirm or time tick. The output channel (out_valid, out_ready, out_data)
// returns the results; the final result of an event carries last. A tick may give
// none, one or several retransmit results; every other event gives exactly one, and
// an unknown kind is dropped without a result.
// A send claims the lowest free slot, if any, and its result then moves to the
// output register before the next event is taken. A confirm or tick scans the slot
// memory slot by slot (address, then evaluate on the registered read data), and the
// next event is taken only once the last result of the scan, if any, has reached
// the output register; a confirm that matches ends its scan at the matching slot.
// One result waits in a pending register and one in the output register. While the
// receiver stalls, a tick scan holds at the next due slot and in_ready stays low.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready: index 0 sets the timeout in ms, index 1 the retry limit. Write it only
// while no event is in flight.
// Reset clears all slot valid bits, the sequence counter and the output, and loads
// a 250 ms timeout and a retry limit of 3. Slot contents are not cleared; they are
// read only behind a valid bit.
`include "retransmit_confirm_table_defines.svh"

module retransmit_confirm_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  rct_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output rct_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rct_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rct_pkg::CFG_DATA_W-1:0]  cfg_data
);

	rct_pkg::cmd_t cmd;
	rct_pkg::sts_t sts;
	logic          result_push;
	logic          event_taken;

	// Registers accept writes in any cycle.
	assign cfg_ready = 1'b1;

	// The controller sequences each event: dispatch, slot write or slot scan, final flush.
	rct_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// The datapath holds the slot memory, valid bits, counters and result registers.
	rct_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_data),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// A result moves from the pending register into the output register.
	assign result_push = cmd.flush || (cmd.tick_hit && sts.pend_valid);
	// An event of a known kind is taken; an unknown kind leaves the controller idle.
	assign event_taken = in_valid && in_ready && in_data.kind <= rct_pkg::KIND_TICK;

	// A new event is only taken once the previous one has no result left in the pending register.
	`RCT_ASSERT_SAME(a_idle_no_pending, clk, arst_n, in_ready, !sts.pend_valid, "result pending")
	// A result moves to the output register only when that register can take it.
	`RCT_ASSERT_SAME(a_push_has_room, clk, arst_n, result_push, sts.out_free, "output full")
	// Each accepted event is worked on before another is taken.
	`RCT_ASSERT_NEXT(a_one_event, clk, arst_n, event_taken, !in_ready, "back to back event")

endmodule

// ===== dv/retransmit_confirm_table_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the retransmission table. The sender offers send, confirm,
// tick and unused-kind events with random gaps. The receiver stalls at random and
// once for a long stretch. Every accepted result is matched against a shadow copy
// of the table that is kept up to date at each accepted input transaction.
module retransmit_confirm_table_tb;

	// The kind code that the block must drop without a result.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	// Register indexes that select nothing; writes to them must have no effect.
	localparam logic [rct_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [rct_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	// Cycles to let pass after the last result, which covers a full scan that ends
	// without a result (an empty tick or a dropped event).
	localparam int SETTLE_CYCLES = 2 * rct_pkg::SLOT_COUNT + 16;
	localparam int LONG_STALL    = 400;
	localparam int PHASE_ITEMS   = 85;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	rct_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready;
	rct_pkg::out_item_t out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [rct_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rct_pkg::CFG_DATA_W-1:0] cfg_data;

	retransmit_confirm_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the table and of its registers.
	logic        shadow_valid   [rct_pkg::SLOT_COUNT];
	logic [15:0] shadow_seq     [rct_pkg::SLOT_COUNT];
	logic [31:0] shadow_sent    [rct_pkg::SLOT_COUNT];
	logic [2:0]  shadow_retries [rct_pkg::SLOT_COUNT];
	logic [15:0] shadow_next_seq;
	logic [15:0] shadow_timeout;
	logic [2:0]  shadow_limit;

	// Results that the block still owes, oldest first.
	rct_pkg::out_item_t pending_results[$];

	// One row of the directed table: the event and, where it is obvious, the one
	// result it must give.
	typedef struct {
		rct_pkg::in_item_t  ev;
		bit                 typed;
		rct_pkg::out_item_t want;
	} dir_row_t;

	dir_row_t dir_rows[$];

	typedef struct {
		logic [15:0] timeout;
		logic [15:0] limit_data;
		int          send_pct;
		bit          steady;
		logic [31:0] start_ms;
	} phase_t;

	bit steady;
	bit stall_req;
	int stall_left;
	int gap_left;
	int n_errors;
	int n_events;
	int n_checked;
	int n_retx;
	int n_full;
	int n_unmatched;
	int n_confirmed;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs; far beyond the slowest correct run.
	initial begin
		#1000000;
		$display("retransmit_confirm_table_tb: done, errors");
		$finish;
	end

	// Works out the results of one event and advances the shadow table the way
	// the block must. A tick re-arms every due slot that still has retries left.
	function automatic void predict_outcome(input rct_pkg::in_item_t ev,
			ref rct_pkg::out_item_t res[$]);
		rct_pkg::out_item_t r;
		logic [31:0]        elapsed;
		int                 n;
		bit                 done;
		n = 0;
		done = 1'b0;
		res.delete();
		r = '0;
		if (ev.kind == rct_pkg::KIND_SEND) begin
			for (int i = 0; i < rct_pkg::SLOT_COUNT && !done; i++) begin
				if (!shadow_valid[i]) begin
					shadow_valid[i]   = 1'b1;
					shadow_seq[i]     = shadow_next_seq;
					shadow_sent[i]    = ev.now_ms;
					shadow_retries[i] = 3'd0;
					r.status     = rct_pkg::STAT_SENT;
					r.slot_index = i[3:0];
					r.seq_out    = shadow_next_seq;
					r.last       = 1'b1;
					shadow_next_seq = shadow_next_seq + 16'd1;
					done = 1'b1;
				end
			end
			if (!done) begin
				// Table full: the sequence number is reported but not consumed.
				r.status  = rct_pkg::STAT_FULL;
				r.seq_out = shadow_next_seq;
				r.last    = 1'b1;
			end
			res.push_back(r);
		end else if (ev.kind == rct_pkg::KIND_CONFIRM) begin
			for (int i = 0; i < rct_pkg::SLOT_COUNT && !done; i++) begin
				if (shadow_valid[i] && shadow_seq[i] == ev.confirm_seq) begin
					shadow_valid[i] = 1'b0;
					r.status      = rct_pkg::STAT_CONFIRMED;
					r.slot_index  = i[3:0];
					r.seq_out     = shadow_seq[i];
					r.retry_count = shadow_retries[i];
					r.last        = 1'b1;
					done = 1'b1;
				end
			end
			if (!done) begin
				r.status  = rct_pkg::STAT_UNMATCHED;
				r.seq_out = ev.confirm_seq;
				r.last    = 1'b1;
			end
			res.push_back(r);
		end else if (ev.kind == rct_pkg::KIND_TICK) begin
			for (int i = 0; i < rct_pkg::SLOT_COUNT && n < rct_pkg::MAX_RESULTS; i++) begin
				if (shadow_valid[i]) begin
					elapsed = ev.now_ms - shadow_sent[i];
					if (elapsed >= {16'd0, shadow_timeout}
							&& shadow_retries[i] < shadow_limit) begin
						shadow_sent[i]    = ev.now_ms;
						shadow_retries[i] = shadow_retries[i] + 3'd1;
						r = '0;
						r.status      = rct_pkg::STAT_RETRANSMIT;
						r.slot_index  = i[3:0];
						r.seq_out     = shadow_seq[i];
						r.retry_count = shadow_retries[i];
						res.push_back(r);
						n++;
					end
				end
			end
			// Only the final retransmit of a tick carries last.
			if (n > 0)
				res[n-1].last = 1'b1;
		end
		// The unused kind leaves the table alone and gives nothing.
	endfunction

	function automatic void add_row(input logic [1:0] kind, input logic [31:0] now,
			input logic [15:0] cseq, input bit typed, input rct_pkg::out_item_t want);
		dir_row_t row;
		row.ev.kind        = kind;
		row.ev.now_ms      = now;
		row.ev.confirm_seq = cseq;
		row.typed          = typed;
		row.want           = want;
		dir_rows.push_back(row);
	endfunction

	function automatic rct_pkg::out_item_t mk_result(input rct_pkg::status_t st,
			input logic [3:0] slot, input logic [15:0] seq, input logic [2:0] retries);
		rct_pkg::out_item_t r;
		r.status      = st;
		r.slot_index  = slot;
		r.seq_out     = seq;
		r.retry_count = retries;
		r.last        = 1'b1;
		return r;
	endfunction

	// Offers one event after a random gap and waits for its transaction. When the
	// gap is zero the valid stays high from the previous event, so it is never
	// lowered and raised at the same edge.
	task automatic offer_event(input rct_pkg::in_item_t ev, input bit typed,
			input rct_pkg::out_item_t want);
		rct_pkg::out_item_t res[$];
		int                 gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= ev;
		do @(posedge clk); while (!in_ready);
		n_events++;
		predict_outcome(ev, res);
		if (typed)
			pending_results.push_back(want);
		else
			foreach (res[k]) pending_results.push_back(res[k]);
	endtask

	// Stops offering, waits for every owed result, then lets a scan's worth of
	// cycles pass so that an event with no result has also finished.
	task automatic drain_table();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rct_pkg::CFG_IDX_W-1:0] idx,
			input logic [rct_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == rct_pkg::CFG_TIMEOUT)
			shadow_timeout = data;
		else if (idx == rct_pkg::CFG_RETRY_LIMIT)
			shadow_limit = data[2:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// The receiver decides out_ready at every falling edge. A long hold-off, once
	// requested, is counted down here and takes precedence over the short gaps.
	initial begin
		out_ready  = 1'b0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_req  = 1'b0;
				stall_left = LONG_STALL;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Every output transaction is checked against the oldest owed result.
	always @(posedge clk) begin
		rct_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			gap_left = steady ? 0 : $urandom_range(0, 3);
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result: status %0d slot %0d seq %0d %s %0d last %0d",
						out_data.status, out_data.slot_index, out_data.seq_out,
						"retries", out_data.retry_count, out_data.last);
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				case (want.status)
					rct_pkg::STAT_RETRANSMIT: n_retx++;
					rct_pkg::STAT_FULL:       n_full++;
					rct_pkg::STAT_UNMATCHED:  n_unmatched++;
					rct_pkg::STAT_CONFIRMED:  n_confirmed++;
					default: ;
				endcase
				if (out_data.status !== want.status
						|| out_data.slot_index !== want.slot_index
						|| out_data.seq_out !== want.seq_out
						|| out_data.retry_count !== want.retry_count
						|| out_data.last !== want.last) begin
					n_errors++;
					if (n_errors <= 10) begin
						$display("mismatch: expected status %0d slot %0d seq %0d %s",
							want.status, want.slot_index, want.seq_out, "and");
						$display("  retries %0d last %0d, got status %0d slot %0d seq %0d",
							want.retry_count, want.last, out_data.status,
							out_data.slot_index, out_data.seq_out);
						$display("  retries %0d last %0d",
							out_data.retry_count, out_data.last);
					end
				end
			end
		end
	end

	initial begin
		phase_t             phases[5];
		rct_pkg::in_item_t  ev;
		rct_pkg::out_item_t none;
		logic [31:0]        cur_ms;
		logic [15:0]        live_seqs[$];
		int                 counted;
		int                 pick;
		int                 step_hi;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		steady    = 1'b0;
		stall_req = 1'b0;
		gap_left  = 0;
		n_errors  = 0;
		n_events  = 0;
		n_checked = 0;
		n_retx    = 0;
		n_full    = 0;
		n_unmatched = 0;
		n_confirmed = 0;
		none      = '0;

		for (int i = 0; i < rct_pkg::SLOT_COUNT; i++) begin
			shadow_valid[i]   = 1'b0;
			shadow_seq[i]     = '0;
			shadow_sent[i]    = '0;
			shadow_retries[i] = '0;
		end
		shadow_next_seq = '0;
		shadow_timeout  = rct_pkg::TIMEOUT_RESET;
		shadow_limit    = rct_pkg::RETRY_LIMIT_RESET;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, run with the reset register values. A confirm on the empty
		// table finds nothing, and a tick on it gives no result at all.
		add_row(rct_pkg::KIND_CONFIRM, 32'h0000_0000, 16'hFFFF, 1'b1,
			mk_result(rct_pkg::STAT_UNMATCHED, 4'd0, 16'hFFFF, 3'd0));
		add_row(rct_pkg::KIND_TICK, 32'h0000_0000, 16'h0000, 1'b0, none);
		// Two sends, the first just before the time counter wraps.
		add_row(rct_pkg::KIND_SEND, 32'hFFFF_FFF0, 16'h0000, 1'b1,
			mk_result(rct_pkg::STAT_SENT, 4'd0, 16'd0, 3'd0));
		add_row(rct_pkg::KIND_SEND, 32'h0000_0000, 16'hFFFF, 1'b1,
			mk_result(rct_pkg::STAT_SENT, 4'd1, 16'd1, 3'd0));
		// The first slot is due across the wrap; the second is one ms short.
		add_row(rct_pkg::KIND_TICK, 32'h0000_00F9, 16'h0000, 1'b0, none);
		// Now the second slot's elapsed time equals the timeout exactly.
		add_row(rct_pkg::KIND_TICK, 32'h0000_00FA, 16'h0000, 1'b0, none);
		add_row(rct_pkg::KIND_CONFIRM, 32'hFFFF_FFFF, 16'h0000, 1'b0, none);
		// The unused kind with every bit set must be dropped silently.
		add_row(KIND_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, none);
		// Fill the table, then one send that finds it full.
		for (int i = 0; i < rct_pkg::SLOT_COUNT - 1; i++)
			add_row(rct_pkg::KIND_SEND, 32'h0000_0100 + i, 16'h0000, 1'b0, none);
		add_row(rct_pkg::KIND_SEND, 32'h0000_0200, 16'h0000, 1'b1,
			mk_result(rct_pkg::STAT_FULL, 4'd0, 16'd17, 3'd0));
		// Far in the future every slot is due: the most results one tick can give.
		add_row(rct_pkg::KIND_TICK, 32'hFFFF_FFFF, 16'h0000, 1'b0, none);

		foreach (dir_rows[r])
			offer_event(dir_rows[r].ev, dir_rows[r].typed, dir_rows[r].want);

		// Random phases, each with its own register setting. The extremes come first:
		// a zero timeout with the most retries, then the longest timeout with none.
		phases[0] = '{16'd0,     16'd7,     40, 1'b0, 32'h0000_1000};
		phases[1] = '{16'hFFFF,  16'hFFF8,  60, 1'b0, 32'h8000_0000};
		phases[2] = '{16'd1,     16'd1,     35, 1'b0, 32'h0000_0000};
		phases[3] = '{rct_pkg::TIMEOUT_RESET, 16'd3, 35, 1'b1, 32'hFFFF_F000};
		phases[4] = '{16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
			$urandom_range(30, 50), 1'b0, $urandom()};

		foreach (phases[p]) begin
			// The sender pauses here until the table has owed nothing for a while.
			drain_table();
			write_reg(rct_pkg::CFG_TIMEOUT, phases[p].timeout);
			write_reg(rct_pkg::CFG_RETRY_LIMIT, phases[p].limit_data);
			if (p == 3) begin
				write_reg(CFG_SPARE_LO, 16'($urandom_range(0, 65535)));
				write_reg(CFG_SPARE_HI, 16'hFFFF);
			end
			steady  = phases[p].steady;
			cur_ms  = phases[p].start_ms;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				// Once, the receiver holds off long enough for the block to back up.
				if (p == 0 && counted == 20)
					stall_req = 1'b1;
				ev.confirm_seq = 16'($urandom_range(0, 65535));
				ev.now_ms      = cur_ms;
				pick = $urandom_range(0, 99);
				if (pick < phases[p].send_pct) begin
					ev.kind = rct_pkg::KIND_SEND;
				end else if (pick < phases[p].send_pct + (96 - phases[p].send_pct) / 2) begin
					ev.kind = rct_pkg::KIND_CONFIRM;
					// Most confirmations name a datagram that is still outstanding.
					live_seqs.delete();
					foreach (shadow_valid[i])
						if (shadow_valid[i])
							live_seqs.push_back(shadow_seq[i]);
					if (live_seqs.size() != 0 && $urandom_range(0, 3) != 0)
						ev.confirm_seq = live_seqs[$urandom_range(0, live_seqs.size() - 1)];
				end else if (pick < 96) begin
					ev.kind = rct_pkg::KIND_TICK;
					step_hi = shadow_timeout + shadow_timeout / 2 + 3;
					cur_ms  = cur_ms + 32'($urandom_range(0, step_hi));
					ev.now_ms = cur_ms;
				end else begin
					ev.kind = KIND_UNUSED;
				end
				// A few events carry an arbitrary time stamp.
				if ($urandom_range(0, 9) == 0)
					ev.now_ms = $urandom();
				offer_event(ev, 1'b0, none);
				if (ev.kind != KIND_UNUSED)
					counted++;
			end
		end

		drain_table();
		$display("covered %0d events over 6 register settings: %0d results checked",
			n_events, n_checked);
		$display("retransmits %0d, table full %0d, confirmed %0d, unmatched %0d, failures %0d",
			n_retx, n_full, n_confirmed, n_unmatched, n_errors);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("retransmit_confirm_table_tb: done, clean");
		else
			$display("retransmit_confirm_table_tb: done, errors");
		$finish;
	end

endmodule
